### hw/rtl/bole_pkg.sv
`default_nettype none

package bole_pkg;

  // List size and derived widths
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IdxW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned PosW     = 5;
  localparam int unsigned CmpW     = (CntW > PosW) ? CntW : PosW;

  // Request codes
  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_INS_KEY   = 3'd3,
    CMD_POP_FRONT = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_UP,
    S_MOVE_UP,
    S_POP_HEAD,
    S_POP_CAP,
    S_DOWN,
    S_MOVE_DN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        [2:0]      cmd;
    logic signed [31:0]     entry_key;
    logic signed [31:0]     entry_value;
    logic        [PosW-1:0] position;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] removed_key;
    logic signed [31:0] removed_value;
    logic        [4:0]  entry_count;
  } rsp_t;

  // One stored list slot
  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] value;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

`default_nettype wire

### hw/rtl/bole_ram.sv
`default_nettype none

module bole_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bounded_ordered_list_engine_unit.sv
`default_nettype none

// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  in_req_i   (req_t)
// out       output     out_valid_o / out_ready_i out_rsp_o (rsp_t)
//
// One request at a time; in_ready_o is high only while the sequencer is idle.
// Each request runs through the sequencer states; each shift step is one read
// and one write of the list memory.
// Reset clears the count and control; list memory contents are not cleared.
// A waiting result is held in the output register; the next request is taken
// meanwhile and its result waits in the done state until the register frees.

module bounded_ordered_list_engine_unit
  import bole_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_ready_o,
  input  wire req_t in_req_i,
  output      logic out_valid_o,
  input  wire logic out_ready_i,
  output      rsp_t out_rsp_o
);

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [IdxW-1:0]      tgt_q, tgt_d;
  req_t                 req_q, req_d;
  status_e              status_q, status_d;
  logic signed [31:0]   rk_q, rk_d;
  logic signed [31:0]   rv_q, rv_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 rsp_q, rsp_d;

  logic                 ram_we, ram_re;
  logic [IdxW-1:0]      ram_waddr, ram_raddr;
  entry_t               ram_wdata, ram_rdata;

  logic                 in_xfer, is_full, is_empty, bad_pos;
  logic                 key_less, scan_end, up_end, down_end, out_free;
  logic [CntW-1:0]      next_up;

  bole_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EntryW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared decode and the one key comparator
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CntW'(CAPACITY));
  assign is_empty   = (count_q == '0);
  assign bad_pos    = (CmpW'(in_req_i.position) > CmpW'(count_q));
  assign key_less   = (ram_rdata.key < req_q.entry_key);
  assign scan_end   = (CntW'(idx_q) == count_q);
  assign up_end     = (idx_q == tgt_q);
  assign next_up    = CntW'(idx_q) + CntW'(1);
  assign down_end   = (next_up == count_q);
  assign out_free   = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_req_i.cmd)
            CMD_INS_FRONT, CMD_INS_BACK: state_d = is_full ? S_DONE : S_UP;
            CMD_INS_POS:   state_d = (bad_pos || is_full) ? S_DONE : S_UP;
            CMD_INS_KEY:   state_d = is_full ? S_DONE : S_SCAN;
            CMD_POP_FRONT: state_d = is_empty ? S_DONE : S_POP_HEAD;
            default:       state_d = S_DONE;
          endcase
        end
      end
      S_SCAN:     state_d = scan_end ? S_UP : S_CMP;
      S_CMP:      state_d = key_less ? S_SCAN : S_UP;
      S_UP:       state_d = up_end ? S_DONE : S_MOVE_UP;
      S_MOVE_UP:  state_d = S_UP;
      S_POP_HEAD: state_d = S_POP_CAP;
      S_POP_CAP:  state_d = S_DOWN;
      S_DOWN:     state_d = down_end ? S_DONE : S_MOVE_DN;
      S_MOVE_DN:  state_d = S_DOWN;
      S_DONE:     state_d = out_free ? S_IDLE : S_DONE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    tgt_d       = tgt_q;
    req_d       = req_q;
    status_d    = status_q;
    rk_d        = rk_q;
    rv_d        = rv_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          req_d    = in_req_i;
          rk_d     = '0;
          rv_d     = '0;
          status_d = STAT_OK;
          idx_d    = IdxW'(count_q);
          tgt_d    = '0;
          unique case (in_req_i.cmd)
            CMD_INS_FRONT: begin
              if (is_full) status_d = STAT_FULL;
            end
            CMD_INS_BACK: begin
              if (is_full) status_d = STAT_FULL;
              tgt_d = IdxW'(count_q);
            end
            CMD_INS_POS: begin
              if (bad_pos) status_d = STAT_BADPOS;
              else if (is_full) status_d = STAT_FULL;
              tgt_d = IdxW'(in_req_i.position);
            end
            CMD_INS_KEY: begin
              if (is_full) status_d = STAT_FULL;
              idx_d = '0;
            end
            CMD_POP_FRONT: begin
              if (is_empty) status_d = STAT_EMPTY;
              idx_d = '0;
            end
            default: status_d = STAT_BADPOS;
          endcase
        end
      end
      // Walk from the front until a key not smaller is found or the list ends
      S_SCAN: begin
        if (scan_end) begin
          tgt_d = idx_q;
          idx_d = IdxW'(count_q);
        end else begin
          ram_re = 1'b1;
        end
      end
      S_CMP: begin
        if (key_less) begin
          idx_d = IdxW'(idx_q + 1'b1);
        end else begin
          tgt_d = idx_q;
          idx_d = IdxW'(count_q);
        end
      end
      // Shift entries up from the back, then drop the new entry in the gap
      S_UP: begin
        if (up_end) begin
          ram_we    = 1'b1;
          ram_wdata = '{key: req_q.entry_key, value: req_q.entry_value};
          count_d   = count_q + CntW'(1);
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IdxW'(idx_q - 1'b1);
        end
      end
      S_MOVE_UP: begin
        ram_we = 1'b1;
        idx_d  = IdxW'(idx_q - 1'b1);
      end
      S_POP_HEAD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_POP_CAP: begin
        rk_d  = ram_rdata.key;
        rv_d  = ram_rdata.value;
        idx_d = '0;
      end
      // Shift remaining entries down toward the front
      S_DOWN: begin
        if (down_end) begin
          count_d = count_q - CntW'(1);
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IdxW'(next_up);
        end
      end
      S_MOVE_DN: begin
        ram_we = 1'b1;
        idx_d  = IdxW'(idx_q + 1'b1);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rsp_d = '{status: status_q, removed_key: rk_q, removed_value: rv_q,
                    entry_count: 5'(count_q)};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    tgt_q    <= tgt_d;
    req_q    <= req_d;
    status_q <= status_d;
    rk_q     <= rk_d;
    rv_q     <= rv_d;
    rsp_q    <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> (count_q == $past(count_q) + CntW'(1)) ||
                          (count_q == $past(count_q) - CntW'(1)))
    else $error("entry count moved by more than one");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one still in work");

  a_zero_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != STAT_OK) |->
      (out_rsp_o.removed_key == '0) && (out_rsp_o.removed_value == '0))
    else $error("removed fields nonzero on failed request");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we && !ram_re)
    else $error("list memory accessed while idle");

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bole_pkg::*;

  // Unused request codes, answered with a bad-position status
  localparam logic [2:0] CMD_RSVD_A = 3'd5;
  localparam logic [2:0] CMD_RSVD_B = 3'd6;
  localparam logic [2:0] CMD_RSVD_C = 3'd7;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  localparam int N_DIR    = 17;
  localparam int N_RANDOM = 900;
  localparam int N_CALM   = 150;
  localparam int EPOCH    = 60;
  localparam int TAIL_CYC = 80;

  // One directed row; typed rows carry their own expected response
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic [PosW-1:0]    pos;
    bit                 typed;
    status_e            st;
    logic signed [31:0] rk;
    logic signed [31:0] rv;
    logic [4:0]         cnt;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_rsp_o;

  bounded_ordered_list_engine_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Shadow copy of the list
  logic signed [31:0] list_key [CAPACITY];
  logic signed [31:0] list_val [CAPACITY];
  int unsigned        list_len;

  rsp_t expected_rsp [$];
  dir_row_t dir_rows [N_DIR];

  int n_err;
  int n_sent;
  int n_checked;
  int n_full;
  int n_empty;
  int n_badpos;
  int unsigned peak_len;
  bit calm;
  int idle_pct;
  int stall_pct;

  // Apply one request to the shadow list and return its response
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int unsigned slot;
    int unsigned i;
    logic signed [31:0] new_key;
    res = '0;
    res.status = STAT_OK;
    new_key = r.entry_key;
    if (r.cmd == CMD_POP_FRONT) begin
      if (list_len == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.removed_key   = list_key[0];
        res.removed_value = list_val[0];
        for (i = 1; i < list_len; i++) begin
          list_key[i-1] = list_key[i];
          list_val[i-1] = list_val[i];
        end
        list_len--;
      end
    end else if (r.cmd > CMD_POP_FRONT) begin
      res.status = STAT_BADPOS;
    end else if (r.cmd == CMD_INS_POS && 32'(r.position) > list_len) begin
      // position check wins over full
      res.status = STAT_BADPOS;
    end else if (list_len >= CAPACITY) begin
      res.status = STAT_FULL;
    end else begin
      case (r.cmd)
        CMD_INS_FRONT: slot = 0;
        CMD_INS_BACK:  slot = list_len;
        CMD_INS_POS:   slot = 32'(r.position);
        default: begin
          // first slot whose key is not smaller
          slot = 0;
          while (slot < list_len && list_key[slot] < new_key) slot++;
        end
      endcase
      for (i = list_len; i > slot; i--) begin
        list_key[i] = list_key[i-1];
        list_val[i] = list_val[i-1];
      end
      list_key[slot] = new_key;
      list_val[slot] = r.entry_value;
      list_len++;
    end
    res.entry_count = list_len[4:0];
    return res;
  endfunction

  // Random request, biased toward inserts or removes
  function automatic req_t random_request(bit filling);
    req_t r;
    int unsigned pick;
    int unsigned sel;
    r.cmd         = CMD_POP_FRONT;
    r.entry_key   = $urandom;
    r.entry_value = $urandom;
    r.position    = PosW'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      r.cmd = 3'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
    end else if ((pick < 80) == filling) begin
      r.cmd = 3'($urandom_range(CMD_INS_FRONT, CMD_INS_KEY));
      if ($urandom_range(0, 99) < 85) r.position = PosW'($urandom_range(0, list_len));
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        // narrow range makes equal keys likely
        r.entry_key = $urandom_range(0, 16) - 8;
      end else if (sel == 4) begin
        case ($urandom_range(0, 3))
          0:       r.entry_key = KEY_MIN;
          1:       r.entry_key = KEY_MAX;
          2:       r.entry_key = '0;
          default: r.entry_key = -32'sd1;
        endcase
      end
    end
    return r;
  endfunction

  // Drive one request and wait for its transfer
  task automatic push_request(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t want;
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    want = apply_request(r);
    case (want.status)
      STAT_FULL:   n_full++;
      STAT_EMPTY:  n_empty++;
      STAT_BADPOS: n_badpos++;
      default: ;
    endcase
    if (list_len > peak_len) peak_len = list_len;
    if (typed) want = typed_rsp;
    expected_rsp.push_back(want);
    n_sent++;
  endtask

  // Optional sender gap before the next request
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Response side: random stall bursts
  initial begin : rsp_sink
    int unsigned hold;
    hold = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold == 0 && !calm && $urandom_range(0, 99) < stall_pct)
        hold = $urandom_range(1, 4);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Response checker
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsp.size() == 0) begin
        $error("response transfer with no request outstanding");
        n_err++;
      end else begin
        want = expected_rsp.pop_front();
        n_checked++;
        if (out_rsp_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_rsp_o.status);
          n_err++;
        end
        if (out_rsp_o.removed_key !== want.removed_key) begin
          $error("removed_key: expected %0d, got %0d", want.removed_key,
                 out_rsp_o.removed_key);
          n_err++;
        end
        if (out_rsp_o.removed_value !== want.removed_value) begin
          $error("removed_value: expected %0d, got %0d", want.removed_value,
                 out_rsp_o.removed_value);
          n_err++;
        end
        if (out_rsp_o.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_rsp_o.entry_count);
          n_err++;
        end
      end
    end
  end

  // Stimulus
  initial begin : stim
    req_t rq;
    rsp_t tr;
    bit filling;
    int d;
    int idx;
    int drain_wait;

    n_err = 0;
    n_sent = 0;
    n_checked = 0;
    n_full = 0;
    n_empty = 0;
    n_badpos = 0;
    peak_len = 0;
    list_len = 0;
    calm = 1'b0;
    idle_pct = 20;
    stall_pct = 20;
    filling = 1'b0;

    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    rst_ni     <= 1'b0;

    // cmd, key, value, pos, typed, status, removed key, removed value, count
    dir_rows = '{
      '{CMD_POP_FRONT, 32'sd0,  32'sd0,   5'd0,  1'b1, STAT_EMPTY,  32'sd0, 32'sd0, 5'd0},
      '{CMD_INS_POS,   32'sd11, 32'sd12,  5'd1,  1'b1, STAT_BADPOS, 32'sd0, 32'sd0, 5'd0},
      '{CMD_RSVD_A,    32'sd3,  32'sd4,   5'd0,  1'b1, STAT_BADPOS, 32'sd0, 32'sd0, 5'd0},
      '{CMD_RSVD_C,    32'sd3,  32'sd4,   5'd0,  1'b1, STAT_BADPOS, 32'sd0, 32'sd0, 5'd0},
      '{CMD_INS_POS,   32'sd1,  32'sd2,   5'd0,  1'b1, STAT_OK,     32'sd0, 32'sd0, 5'd1},
      '{CMD_POP_FRONT, 32'sd0,  32'sd0,   5'd0,  1'b1, STAT_OK,     32'sd1, 32'sd2, 5'd0},
      '{CMD_INS_KEY,   KEY_MIN, KEY_MAX,  5'd0,  1'b1, STAT_OK,     32'sd0, 32'sd0, 5'd1},
      '{CMD_INS_FRONT, KEY_MAX, KEY_MIN,  5'd0,  1'b1, STAT_OK,     32'sd0, 32'sd0, 5'd2},
      '{CMD_INS_BACK,  32'sd0,  -32'sd1,  5'd0,  1'b1, STAT_OK,     32'sd0, 32'sd0, 5'd3},
      '{CMD_INS_POS,   32'sd5,  32'sd5,   5'd3,  1'b1, STAT_OK,     32'sd0, 32'sd0, 5'd4},
      '{CMD_INS_POS,   32'sd6,  32'sd6,   5'd31, 1'b1, STAT_BADPOS, 32'sd0, 32'sd0, 5'd4},
      '{CMD_INS_KEY,   -32'sd1, 32'sd100, 5'd0,  1'b0, STAT_OK,     32'sd0, 32'sd0, 5'd0},
      '{CMD_INS_KEY,   32'sd0,  32'sd101, 5'd0,  1'b0, STAT_OK,     32'sd0, 32'sd0, 5'd0},
      '{CMD_RSVD_B,    KEY_MAX, KEY_MAX,  5'd31, 1'b1, STAT_BADPOS, 32'sd0, 32'sd0, 5'd6},
      '{CMD_POP_FRONT, 32'sd0,  32'sd0,   5'd0,  1'b1, STAT_OK,    -32'sd1, 32'sd100, 5'd5},
      '{CMD_POP_FRONT, 32'sd0,  32'sd0,   5'd0,  1'b0, STAT_OK,     32'sd0, 32'sd0, 5'd0},
      '{CMD_INS_BACK,  KEY_MAX, 32'sd0,   5'd16, 1'b0, STAT_OK,     32'sd0, 32'sd0, 5'd0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (d = 0; d < N_DIR; d++) begin
      sender_gap();
      rq.cmd            = dir_rows[d].cmd;
      rq.entry_key      = dir_rows[d].key;
      rq.entry_value    = dir_rows[d].value;
      rq.position       = dir_rows[d].pos;
      tr.status         = dir_rows[d].st;
      tr.removed_key    = dir_rows[d].rk;
      tr.removed_value  = dir_rows[d].rv;
      tr.entry_count    = dir_rows[d].cnt;
      push_request(rq, dir_rows[d].typed, tr);
    end

    // Random part: alternating fill and drain epochs, quiet at the end
    for (idx = 0; idx < N_RANDOM; idx++) begin
      if (idx % EPOCH == 0) begin
        filling = !filling;
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 35;
        endcase
      end
      calm = (idx >= N_RANDOM - N_CALM);
      rq = random_request(filling);
      sender_gap();
      push_request(rq, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // Drain outstanding responses, then let the block settle
    drain_wait = 0;
    while (expected_rsp.size() != 0 && drain_wait < 4000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (TAIL_CYC) @(posedge clk_i);
    if (expected_rsp.size() != 0) begin
      $error("%0d responses never arrived", expected_rsp.size());
      n_err++;
    end

    $display("Sent %0d requests, checked %0d responses, peak list length %0d",
             n_sent, n_checked, peak_len);
    $display("Rejections seen: full %0d, empty %0d, bad position %0d",
             n_full, n_empty, n_badpos);
    if (n_err == 0) begin
      $display("[bounded_ordered_list_engine_unit] OK");
    end else begin
      $display("[bounded_ordered_list_engine_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("[bounded_ordered_list_engine_unit] ERROR");
    $finish;
  end

endmodule

### bounded_ordered_list_engine_unit.f
hw/rtl/bole_pkg.sv
hw/rtl/bole_ram.sv
hw/rtl/bounded_ordered_list_engine_unit.sv
verif/tb_top.sv
